@@ rtl/core/sicos_pkg.sv @@
// ----------------------------------------------------------------------------
// sicos_pkg
// Types and constants shared by the sparse item cosine similarity block.
// ----------------------------------------------------------------------------
package sicos_pkg;

    // default sizes of the rating store and the item table
    localparam int MAX_RATINGS_DEF = 4096;
    localparam int NUM_ITEMS_DEF   = 1024;

    // width of the clamped cosine quotient (clamp at 2^40)
    localparam int Q_CLAMP_W = 41;

    // operation codes
    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_ORDER = 2'd2,
        ST_BAD   = 2'd3
    } t_status;

    // input transfer
    typedef struct packed {
        logic [1:0]         operation;
        logic [15:0]        user_id;
        logic [9:0]         item_a;
        logic [9:0]         item_b;
        logic signed [15:0] rating_score;
    } t_in_item;

    // result transfer
    typedef struct packed {
        logic signed [31:0] similarity;
        logic [12:0]        common_count;
        logic               defined;
        logic [1:0]         status;
    } t_out_item;

endpackage

@@ rtl/core/sparse_item_cosine_similarity.sv @@
// ----------------------------------------------------------------------------
// sparse_item_cosine_similarity
// Sparse rating store with damped item-item cosine similarity queries.
// ----------------------------------------------------------------------------
// Ratings are appended sorted by item, then by user; a query merges two item
// columns out of the rating RAM and returns the damped cosine in Q16.16.
// Every transfer ends in S_DONE before the next input is taken; append and
// unused codes go there straight from S_IDLE. Clear, and also reset, run a
// clearing pass over the column RAM (start and length per item) during which no
// input is taken. A query merges the two columns, one merge step per cycle
// through the rating RAM's two read ports and at most len_a + len_b steps, then
// uses the shared square-root unit twice and the shared divider twice (cosine,
// then damping factor).
// A result waits in the output register while the next transfer is taken.
// ----------------------------------------------------------------------------
module sparse_item_cosine_similarity #(
    parameter int MAX_RATINGS = sicos_pkg::MAX_RATINGS_DEF,
    parameter int NUM_ITEMS   = sicos_pkg::NUM_ITEMS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  sicos_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output sicos_pkg::t_out_item o_out_data,
    input  logic                 i_cfg_we,
    input  logic [11:0]          i_cfg_wdata
);

    localparam int AW  = $clog2(MAX_RATINGS);
    localparam int CW  = $clog2(MAX_RATINGS + 1);
    localparam int IW  = $clog2(NUM_ITEMS);
    localparam int DW  = 32 + CW;
    localparam int NW  = 31 + CW;
    localparam int VW0 = NW + 16;
    localparam int VW  = VW0 + (VW0 % 2);
    localparam int RW  = VW / 2;
    localparam int QW  = DW + 32;
    localparam int EW  = 2 * RW;
    localparam int FW  = (CW > 12) ? CW : 12;
    localparam int SW  = sicos_pkg::Q_CLAMP_W;
    localparam int PW  = SW + FW;
    localparam logic [QW-1:0] QLIM = QW'(1) << (SW - 1);

    typedef enum logic [13:0] {
        S_CLR   = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_COL   = 14'b00000000000100,
        S_MERGE = 14'b00000000001000,
        S_DRAIN = 14'b00000000010000,
        S_CHK   = 14'b00000000100000,
        S_SQA   = 14'b00000001000000,
        S_SQB   = 14'b00000010000000,
        S_MUL   = 14'b00000100000000,
        S_DIV   = 14'b00001000000000,
        S_FAC   = 14'b00010000000000,
        S_SCL   = 14'b00100000000000,
        S_SAT   = 14'b01000000000000,
        S_DONE  = 14'b10000000000000
    } t_state;

    t_state               r_state, n_state;
    logic                 r_ovalid, n_ovalid;
    sicos_pkg::t_out_item r_out, n_out;
    sicos_pkg::t_out_item r_res, n_res;
    logic                 r_pend, n_pend;
    logic [IW-1:0]        r_clr_idx, n_clr_idx;
    logic [11:0]          r_damp;
    logic [CW-1:0]        r_count, n_count;
    logic                 r_last_valid, n_last_valid;
    logic [9:0]           r_last, n_last;
    logic [15:0]          r_last_user, n_last_user;
    logic [CW-1:0]        r_cur_len, n_cur_len;
    logic [AW-1:0]        r_cur_start, n_cur_start;

    // query state
    logic [9:0]           r_ia, n_ia, r_ib, n_ib;
    logic [CW-1:0]        r_i, n_i, r_iend, n_iend;
    logic [CW-1:0]        r_j, n_j, r_jend, n_jend;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic                 r_pv, n_pv;
    logic signed [31:0]   r_pd, r_pa, r_pb;
    logic signed [DW-1:0] r_dot, n_dot;
    logic [NW-1:0]        r_na, n_na, r_nb, n_nb;
    logic [RW-1:0]        r_ra, n_ra, r_rb, n_rb;
    logic [SW-1:0]        r_q, n_q;
    logic [FW-1:0]        r_fac, n_fac;
    logic [PW-1:0]        r_prod;

    // memory ports
    logic                 rat_we;
    logic [31:0]          rat_rd_a, rat_rd_b;
    logic [AW-1:0]        st_rd_a, st_rd_b;
    logic                 len_we;
    logic [IW-1:0]        len_waddr;
    logic [CW-1:0]        len_wdata;
    logic [AW-1:0]        col_start_w;
    logic [CW-1:0]        len_rd_a, len_rd_b;
    logic [AW+CW-1:0]     col_rd_a, col_rd_b;

    // arithmetic units
    logic                 sq_start, sq_done;
    logic [VW-1:0]        sq_value;
    logic [RW-1:0]        sq_root;
    logic                 div_start, div_done;
    logic [QW-1:0]        div_num, div_quot;
    logic [EW-1:0]        div_den;

    logic                 accept, bad_a, bad_b, new_col, active;
    logic [15:0]          ua, ub;
    logic signed [15:0]   sa, sb;
    logic                 neg;
    logic [DW-1:0]        mag;
    logic [11:0]          damp_eff;
    logic [FW-1:0]        fac_num;
    logic [31:0]          sat_mag;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign bad_a    = 32'(i_in_data.item_a) >= NUM_ITEMS;
    assign bad_b    = 32'(i_in_data.item_b) >= NUM_ITEMS;
    assign new_col  = !r_last_valid || (i_in_data.item_a != r_last);
    assign active   = (r_i < r_iend) && (r_j < r_jend);
    assign ua       = rat_rd_a[31:16];
    assign ub       = rat_rd_b[31:16];
    assign sa       = $signed(rat_rd_a[15:0]);
    assign sb       = $signed(rat_rd_b[15:0]);
    assign neg      = r_dot[DW-1];
    assign mag      = neg ? DW'(-r_dot) : DW'(r_dot);
    assign damp_eff = (r_damp == 12'd0) ? 12'd1 : r_damp;
    assign fac_num  = (FW'(r_cnt) > FW'(damp_eff)) ? FW'(r_cnt) : FW'(damp_eff);

    // column descriptor fields: {start, length}
    assign st_rd_a  = col_rd_a[AW+CW-1:CW];
    assign st_rd_b  = col_rd_b[AW+CW-1:CW];
    assign len_rd_a = col_rd_a[CW-1:0];
    assign len_rd_b = col_rd_b[CW-1:0];

    // arithmetic unit operands
    assign sq_value  = (r_state == S_CHK) ? VW'({r_na, 16'b0}) : VW'({r_nb, 16'b0});
    assign sq_start  = ((r_state == S_CHK) && (n_state == S_SQA))
                    || ((r_state == S_SQA) && sq_done);
    assign div_start = (r_state == S_MUL) || ((r_state == S_DIV) && div_done);
    assign div_num   = (r_state == S_MUL) ? {mag, 32'b0} : QW'(fac_num);
    assign div_den   = (r_state == S_MUL) ? EW'(r_ra * r_rb) : EW'(damp_eff);

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_ovalid     = r_ovalid;
        n_out        = r_out;
        n_res        = r_res;
        n_pend       = r_pend;
        n_clr_idx    = r_clr_idx;
        n_count      = r_count;
        n_last_valid = r_last_valid;
        n_last       = r_last;
        n_last_user  = r_last_user;
        n_cur_len    = r_cur_len;
        n_cur_start  = r_cur_start;
        n_ia         = r_ia;
        n_ib         = r_ib;
        n_i          = r_i;
        n_iend       = r_iend;
        n_j          = r_j;
        n_jend       = r_jend;
        n_cnt        = r_cnt;
        n_pv         = 1'b0;
        n_dot        = r_pv ? r_dot + DW'(r_pd) : r_dot;
        n_na         = r_pv ? r_na + NW'($unsigned(r_pa)) : r_na;
        n_nb         = r_pv ? r_nb + NW'($unsigned(r_pb)) : r_nb;
        n_ra         = r_ra;
        n_rb         = r_rb;
        n_q          = r_q;
        n_fac        = r_fac;
        rat_we       = 1'b0;
        len_we       = 1'b0;
        len_waddr    = IW'(i_in_data.item_a);
        len_wdata    = CW'(1);
        col_start_w  = r_cur_start;
        sat_mag      = '0;

        // output register drains independently
        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_CLR: begin
                len_we      = 1'b1;
                len_waddr   = r_clr_idx;
                len_wdata   = '0;
                col_start_w = '0;
                n_clr_idx   = r_clr_idx + 1'b1;
                if (r_clr_idx == IW'(NUM_ITEMS - 1)) begin
                    n_state = r_pend ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_res   = '0;
                    n_state = S_DONE;
                    n_ia    = i_in_data.item_a;
                    n_ib    = i_in_data.item_b;
                    unique case (i_in_data.operation)
                        sicos_pkg::OP_APPEND: begin
                            if (bad_a) begin
                                n_res.status = sicos_pkg::ST_BAD;
                            end else if (r_count >= CW'(MAX_RATINGS)) begin
                                n_res.status = sicos_pkg::ST_FULL;
                            end else if (r_last_valid && (i_in_data.item_a < r_last
                                    || (i_in_data.item_a == r_last
                                        && i_in_data.user_id <= r_last_user))) begin
                                n_res.status = sicos_pkg::ST_ORDER;
                            end else begin
                                rat_we       = 1'b1;
                                len_we       = 1'b1;
                                len_wdata    = new_col ? CW'(1) : r_cur_len + 1'b1;
                                col_start_w  = new_col ? r_count[AW-1:0] : r_cur_start;
                                n_cur_len    = len_wdata;
                                n_cur_start  = col_start_w;
                                n_count      = r_count + 1'b1;
                                n_last_valid = 1'b1;
                                n_last       = i_in_data.item_a;
                                n_last_user  = i_in_data.user_id;
                            end
                        end
                        sicos_pkg::OP_QUERY: begin
                            if (bad_a || bad_b) begin
                                n_res.status = sicos_pkg::ST_BAD;
                            end else begin
                                n_state = S_COL;
                            end
                        end
                        sicos_pkg::OP_CLEAR: begin
                            n_count      = '0;
                            n_last_valid = 1'b0;
                            n_last       = '0;
                            n_last_user  = '0;
                            n_cur_len    = '0;
                            n_cur_start  = '0;
                            n_clr_idx    = '0;
                            n_pend       = 1'b1;
                            n_state      = S_CLR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_COL: begin
                // column descriptors arrived; empty columns merge nothing
                n_i    = (len_rd_a != '0) ? CW'(st_rd_a) : '0;
                n_iend = (len_rd_a != '0) ? CW'(st_rd_a) + len_rd_a : '0;
                n_j    = (len_rd_b != '0) ? CW'(st_rd_b) : '0;
                n_jend = (len_rd_b != '0) ? CW'(st_rd_b) + len_rd_b : '0;
                n_cnt  = '0;
                n_dot  = '0;
                n_na   = '0;
                n_nb   = '0;
                n_state = S_MERGE;
            end
            S_MERGE: begin
                // one merge step per cycle; next addresses go straight to the RAM
                if (active) begin
                    if (ua == ub) begin
                        n_i   = r_i + 1'b1;
                        n_j   = r_j + 1'b1;
                        n_cnt = r_cnt + 1'b1;
                        n_pv  = 1'b1;
                    end else if (ua > ub) begin
                        n_j = r_j + 1'b1;
                    end else begin
                        n_i = r_i + 1'b1;
                    end
                end else begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                n_res.common_count = 13'(r_cnt);
                if ((r_ia == r_ib) || (r_na == '0) || (r_nb == '0)) begin
                    n_state = S_DONE;
                end else begin
                    n_res.defined = 1'b1;
                    n_state       = S_SQA;
                end
            end
            S_SQA: begin
                if (sq_done) begin
                    n_ra    = sq_root;
                    n_state = S_SQB;
                end
            end
            S_SQB: begin
                if (sq_done) begin
                    n_rb    = sq_root;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_q     = (div_quot > QLIM) ? SW'(QLIM) : SW'(div_quot);
                    n_state = S_FAC;
                end
            end
            S_FAC: begin
                if (div_done) begin
                    n_fac   = FW'(div_quot);
                    n_state = S_SCL;
                end
            end
            S_SCL: begin
                n_state = S_SAT;
            end
            S_SAT: begin
                // saturate to Q16.16 with the sign of the dot product
                if (neg) begin
                    sat_mag = (r_prod > PW'(33'h080000000)) ? 32'h80000000 : r_prod[31:0];
                    n_res.similarity = $signed(32'd0 - sat_mag);
                end else begin
                    sat_mag = (r_prod > PW'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : r_prod[31:0];
                    n_res.similarity = $signed(sat_mag);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid = 1'b1;
                    n_out    = r_res;
                    n_pend   = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_ovalid     <= 1'b0;
            r_pend       <= 1'b0;
            r_clr_idx    <= '0;
            r_damp       <= 12'd1;
            r_count      <= '0;
            r_last_valid <= 1'b0;
            r_last       <= '0;
            r_last_user  <= '0;
            r_cur_len    <= '0;
            r_cur_start  <= '0;
            r_pv         <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ovalid     <= n_ovalid;
            r_pend       <= n_pend;
            r_clr_idx    <= n_clr_idx;
            r_count      <= n_count;
            r_last_valid <= n_last_valid;
            r_last       <= n_last;
            r_last_user  <= n_last_user;
            r_cur_len    <= n_cur_len;
            r_cur_start  <= n_cur_start;
            r_pv         <= n_pv;
            if (i_cfg_we) begin
                r_damp <= i_cfg_wdata;
            end
        end
        r_out  <= n_out;
        r_res  <= n_res;
        r_ia   <= n_ia;
        r_ib   <= n_ib;
        r_i    <= n_i;
        r_iend <= n_iend;
        r_j    <= n_j;
        r_jend <= n_jend;
        r_cnt  <= n_cnt;
        r_dot  <= n_dot;
        r_na   <= n_na;
        r_nb   <= n_nb;
        r_ra   <= n_ra;
        r_rb   <= n_rb;
        r_q    <= n_q;
        r_fac  <= n_fac;
        // score products, registered, then accumulated in the next cycle
        r_pd   <= sa * sb;
        r_pa   <= sa * sa;
        r_pb   <= sb * sb;
        r_prod <= r_q * r_fac;
    end

    // rating store: {user, score}
    sicos_ram #(.WIDTH(32), .DEPTH(MAX_RATINGS)) u_rating_ram (
        .i_clk     (i_clk),
        .i_we      (rat_we),
        .i_waddr   (r_count[AW-1:0]),
        .i_wdata   ({i_in_data.user_id, i_in_data.rating_score}),
        .i_raddr_a (n_i[AW-1:0]),
        .i_raddr_b (n_j[AW-1:0]),
        .o_rdata_a (rat_rd_a),
        .o_rdata_b (rat_rd_b)
    );

    // column start and length per item
    sicos_ram #(.WIDTH(AW + CW), .DEPTH(NUM_ITEMS)) u_col_ram (
        .i_clk     (i_clk),
        .i_we      (len_we),
        .i_waddr   (len_waddr),
        .i_wdata   ({col_start_w, len_wdata}),
        .i_raddr_a (IW'(i_in_data.item_a)),
        .i_raddr_b (IW'(i_in_data.item_b)),
        .o_rdata_a (col_rd_a),
        .o_rdata_b (col_rd_b)
    );

    sicos_isqrt #(.VW(VW)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (sq_value),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    sicos_div #(.NW(QW), .DW(EW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

@@ rtl/core/sicos_ram.sv @@
// ----------------------------------------------------------------------------
// sicos_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module sicos_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

@@ rtl/core/sicos_isqrt.sv @@
// ----------------------------------------------------------------------------
// sicos_isqrt
// Iterative floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module sicos_isqrt #(
    parameter int VW = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [VW-1:0]   i_value,
    output logic            o_done,
    output logic [VW/2-1:0] o_root
);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [VW-1:0] r_v, n_v;
    logic [VW-1:0] r_res, n_res;
    logic [VW-1:0] r_bit, n_bit;
    logic [VW-1:0] trial;

    // one digit step
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_v    = r_v;
        n_res  = r_res;
        n_bit  = r_bit;
        trial  = r_res + r_bit;
        if (i_start) begin
            n_busy = 1'b1;
            n_v    = i_value;
            n_res  = '0;
            n_bit  = VW'(1) << (VW - 2);
        end else if (r_busy) begin
            if (r_v >= trial) begin
                n_v   = r_v - trial;
                n_res = (r_res >> 1) + r_bit;
            end else begin
                n_res = r_res >> 1;
            end
            n_bit = r_bit >> 2;
            if (r_bit[0]) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_v   <= n_v;
        r_res <= n_res;
        r_bit <= n_bit;
    end

    assign o_done = r_done;
    assign o_root = r_res[VW/2-1:0];

endmodule

@@ rtl/core/sicos_div.sv @@
// ----------------------------------------------------------------------------
// sicos_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sicos_div #(
    parameter int NW = 80,
    parameter int DW = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);

    localparam int CNTW = $clog2(NW + 1);

    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [NW-1:0]   r_num, n_num;
    logic [DW-1:0]   r_den, n_den;
    logic [DW-1:0]   r_rem, n_rem;
    logic [DW:0]     rem_sh;
    logic            qbit;

    // shift in one numerator bit, subtract when it fits
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_den  = r_den;
        n_rem  = r_rem;
        rem_sh = {r_rem, r_num[NW-1]};
        qbit   = rem_sh >= {1'b0, r_den};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNTW'(NW);
            n_num  = i_num;
            n_den  = i_den;
            n_rem  = '0;
        end else if (r_busy) begin
            n_rem = qbit ? DW'(rem_sh - {1'b0, r_den}) : rem_sh[DW-1:0];
            n_num = {r_num[NW-2:0], qbit};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNTW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_num <= n_num;
        r_den <= n_den;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

@@ rtl/core/sicos_checker.sv @@
// ----------------------------------------------------------------------------
// sicos_checker
// Port-level checks for the sparse item cosine similarity block.
// ----------------------------------------------------------------------------
module sicos_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input sicos_pkg::t_in_item  i_in_data,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input sicos_pkg::t_out_item o_out_data,
    input logic                 i_cfg_we,
    input logic [11:0]          i_cfg_wdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // reset starts the clearing pass, so input is held off
    a_rst_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input taken right after reset");

    // an accepted transfer makes the block stall input in the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("back-to-back input transfer");

    // an undefined or failed result carries no similarity
    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (!o_out_data.defined || o_out_data.status != sicos_pkg::ST_OK)
        |-> o_out_data.similarity == 32'sd0)
        else $error("similarity on undefined result");

endmodule

bind sparse_item_cosine_similarity sicos_checker u_checker (.*);
